// ----- rtl/mlpq_pkg.sv -----
// Shared types and codes for the multilevel priority FIFO.
// Holds the input and result words, the status codes and the sequencer states.
// No dependencies.
`default_nettype none

package mlpq_pkg;

  // Width of the level field on both channels
  localparam int unsigned LEVEL_W = 4;

  // Item kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Status codes reported with every result
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEVEL  = 2'd1;
  localparam logic [1:0] STATUS_LEVEL_FULL = 2'd2;
  localparam logic [1:0] STATUS_EMPTY      = 2'd3;

  // Head value reported while the queue is empty
  localparam logic [31:0] EMPTY_VALUE = 32'hFFFF_FFFF;

  // Input word
  typedef struct packed {
    logic               kind;
    logic signed [31:0] value;
    logic [3:0]         level;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] head_value;
    logic [3:0]         head_level;
    logic               queue_empty;
    logic [1:0]         status;
  } out_word_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } fsm_t;

endpackage

`default_nettype wire

// ----- rtl/mlpq_ram.sv -----
// Entry store of the multilevel priority FIFO: one write port, one read port.
// Read data is registered. Uses no package items.
`default_nettype none

module mlpq_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/multilevel_priority_fifo.sv -----
// Top level of the multilevel priority FIFO: sequencer, per-level pointers and counts.
// Depends on mlpq_pkg and mlpq_ram.
//
// Usage
//   Input channel: drive in_word and raise start; the word is taken at a rising
//   edge where start is high and busy is low. An insert appends value to the FIFO
//   of its level (1 lowest, NUM_LEVELS highest); a remove pops the oldest entry of
//   the highest non-empty level.
//   Result channel: one result word per input word, shown on out_word for exactly
//   one cycle while out_valid is high. It carries the head after the operation
//   (value -1 and level 0 when empty), an empty flag and a status code.
//   Timing: after the accepting edge the sequencer passes through S_READ and then
//   S_SEND; out_valid is high in S_SEND and busy is high in both states, so a new
//   word is only taken after the result of the last one has been shown. This comes
//   from the entry memory: the operation writes it in the accept cycle, the new
//   head is read in S_READ, and its registered data is reported in S_SEND.
//   Reset: synchronous, active low; all levels become empty at once. The entry
//   memory is not cleared, since an entry is only read after it was written.
//   The receiver cannot stall; a result not taken in its cycle is gone.
`default_nettype none

module multilevel_priority_fifo #(
  parameter int unsigned NUM_LEVELS  = 8,
  parameter int unsigned LEVEL_DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mlpq_pkg::in_word_t in_word,
  output logic                    out_valid,
  output mlpq_pkg::out_word_t     out_word
);

  localparam int unsigned IW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int unsigned PW    = $clog2(LEVEL_DEPTH);
  localparam int unsigned CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = mlpq_pkg::LEVEL_W;

  localparam logic [LW-1:0] TOP_LEVEL = LW'(NUM_LEVELS);
  localparam logic [CW-1:0] FULL_CNT  = CW'(LEVEL_DEPTH);
  localparam logic [PW-1:0] LAST_PTR  = PW'(LEVEL_DEPTH - 1);

  // Sequencer and per-level bookkeeping
  mlpq_pkg::fsm_t state_r, state_nxt;
  logic [PW-1:0]  rd_ptr_r [NUM_LEVELS];
  logic [PW-1:0]  wr_ptr_r [NUM_LEVELS];
  logic [CW-1:0]  cnt_r    [NUM_LEVELS];
  logic [LW-1:0]  top_r, top_nxt;
  logic [1:0]     status_r, status_nxt;

  logic            accept;
  logic            is_insert;
  logic            bad_level;
  logic            top_empty;
  logic [IW-1:0]   top_idx;
  logic [IW-1:0]   op_idx;
  logic [IW-1:0]   meta_idx;
  logic [PW-1:0]   meta_rd_ptr;
  logic [PW-1:0]   meta_wr_ptr;
  logic [CW-1:0]   meta_cnt;
  logic            do_insert;
  logic            do_remove;
  logic [NUM_LEVELS-1:0] ne_after;
  logic [LW-1:0]   top_find;

  logic            ram_wr_en;
  logic [AW-1:0]   ram_wr_addr;
  logic            ram_rd_en;
  logic [AW-1:0]   ram_rd_addr;
  logic [31:0]     ram_rd_data;

  assign accept    = start && (state_r == mlpq_pkg::S_IDLE);
  assign is_insert = (in_word.kind == mlpq_pkg::KIND_INSERT);
  assign bad_level = (in_word.level == '0) || (in_word.level > TOP_LEVEL);
  assign top_empty = (top_r == '0);
  assign top_idx   = IW'(top_r - LW'(1));

  // Select the level the operation works on
  assign op_idx   = is_insert ? IW'(in_word.level - LW'(1)) : top_idx;
  assign meta_idx = (state_r == mlpq_pkg::S_IDLE) ? op_idx : top_idx;

  // Single read of the level bookkeeping
  assign meta_rd_ptr = rd_ptr_r[meta_idx];
  assign meta_wr_ptr = wr_ptr_r[meta_idx];
  assign meta_cnt    = cnt_r[meta_idx];

  // Decide the operation and its status
  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    status_nxt = status_r;
    if (accept) begin
      if (is_insert) begin
        if (bad_level) begin
          status_nxt = mlpq_pkg::STATUS_BAD_LEVEL;
        end else if (meta_cnt == FULL_CNT) begin
          status_nxt = mlpq_pkg::STATUS_LEVEL_FULL;
        end else begin
          status_nxt = mlpq_pkg::STATUS_OK;
          do_insert  = 1'b1;
        end
      end else begin
        if (top_empty) begin
          status_nxt = mlpq_pkg::STATUS_EMPTY;
        end else begin
          status_nxt = mlpq_pkg::STATUS_OK;
          do_remove  = 1'b1;
        end
      end
    end
  end

  // Occupancy after a remove, and the highest level still holding entries
  always_comb begin
    for (int unsigned l = 0; l < NUM_LEVELS; l++) begin
      ne_after[l] = (cnt_r[l] != '0);
    end
    if (meta_cnt == CW'(1)) begin
      ne_after[op_idx] = 1'b0;
    end
    top_find = '0;
    for (int unsigned l = 0; l < NUM_LEVELS; l++) begin
      if (ne_after[l]) begin
        top_find = LW'(l + 1);
      end
    end
  end

  // Track the head level
  always_comb begin
    top_nxt = top_r;
    if (do_insert && (in_word.level > top_r)) begin
      top_nxt = in_word.level;
    end else if (do_remove) begin
      top_nxt = top_find;
    end
  end

  // Update pointers and counts of the level touched, the head level and the status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned l = 0; l < NUM_LEVELS; l++) begin
        rd_ptr_r[l] <= '0;
        wr_ptr_r[l] <= '0;
        cnt_r[l]    <= '0;
      end
      top_r    <= '0;
      status_r <= mlpq_pkg::STATUS_OK;
    end else begin
      top_r    <= top_nxt;
      status_r <= status_nxt;
      if (do_insert) begin
        wr_ptr_r[op_idx] <= (meta_wr_ptr == LAST_PTR) ? '0 : meta_wr_ptr + PW'(1);
        cnt_r[op_idx]    <= meta_cnt + CW'(1);
      end
      if (do_remove) begin
        rd_ptr_r[op_idx] <= (meta_rd_ptr == LAST_PTR) ? '0 : meta_rd_ptr + PW'(1);
        cnt_r[op_idx]    <= meta_cnt - CW'(1);
      end
    end
  end

  // Entry memory: write on insert, read the new head in the next cycle
  assign ram_wr_en   = do_insert;
  assign ram_wr_addr = AW'(op_idx * LEVEL_DEPTH) + AW'(meta_wr_ptr);
  assign ram_rd_en   = (state_r == mlpq_pkg::S_READ) && !top_empty;
  assign ram_rd_addr = AW'(top_idx * LEVEL_DEPTH) + AW'(meta_rd_ptr);

  mlpq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (32)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_word.value),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      mlpq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_nxt = mlpq_pkg::S_READ;
        end
      end
      mlpq_pkg::S_READ: begin
        state_nxt = mlpq_pkg::S_SEND;
      end
      mlpq_pkg::S_SEND: begin
        out_valid = 1'b1;
        state_nxt = mlpq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mlpq_pkg::S_IDLE;
      end
    endcase
  end

  // Result word
  always_comb begin
    out_word.head_value  = top_empty ? mlpq_pkg::EMPTY_VALUE : ram_rd_data;
    out_word.head_level  = top_r;
    out_word.queue_empty = top_empty;
    out_word.status      = status_r;
  end

  // An accepted word is reported by the out_valid strobe once the sequencer reaches S_SEND
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe not two cycles after accept");

  // The block is free again right after reporting
  a_free_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("still busy after result");

  // The head level always holds entries
  a_top_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r != '0) |-> (cnt_r[top_idx] != '0))
    else $error("head level is empty");

  // A full level implies a non-empty queue
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status == mlpq_pkg::STATUS_LEVEL_FULL)) |-> !out_word.queue_empty)
    else $error("level full reported on empty queue");

endmodule

`default_nettype wire
